// ----- rtl/core/ivlcd_pkg.sv -----
// ============================================================================
// ivlcd_pkg - shared types and table for the interleaved VLC decoder
// Holds the codeword table lookup and the records passed between the
// pipeline stages.
// ============================================================================
`default_nettype none

package ivlcd_pkg;

    localparam int SEG_BITS = 8;

    localparam logic [3:0] LEN_CONTINUE = 4'd8;
    localparam logic [3:0] LEN_NONE     = 4'd0;

    typedef struct packed {
        logic       valid;
        logic       prior_ovf;
        logic [6:0] avail;
    } ivlcd_s1_t;

    typedef struct packed {
        logic       valid;
        logic       ovf;
        logic [6:0] total;
        logic [3:0] full_count;
        logic       take_odd;
        logic [3:0] odd_len;
        logic [3:0] odd_bits;
    } ivlcd_s2_t;

    // The table is regular enough to be decoded from the index bits: a set top
    // bit gives a one-bit codeword, then three-, five-, seven- and eight-bit
    // segments follow the usual interleaved prefix pattern.
    function automatic logic [7:0] vlc_entry(input logic [7:0] idx);
        logic [7:0] e;
        if (idx[7])
        begin
            e = 8'h10;
        end
        else if (idx[5])
        begin
            e = {7'b0011000, idx[6]};
        end
        else if (idx[3])
        begin
            e = {6'b010100, idx[6], idx[4]};
        end
        else if (idx[1])
        begin
            e = {5'b01110, idx[6], idx[4], idx[2]};
        end
        else
        begin
            e = {4'b1000, idx[6], idx[4], idx[2], idx[0]};
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/interleaved_vlc_decoder.sv -----
// ============================================================================
// interleaved_vlc_decoder - interleaved VLC header codeword decoder
// Decodes one codeword from an MSB-first bit window in a three-stage
// pipeline: table lookup, segment scan and value assembly.
//
//   Channel   Direction  Handshake      Fields
//   request   in         start / busy   bit_window, valid_bits, prior_overrun
//   result    out        done           code_value, code_length, overrun
//
// A request is taken in every cycle; busy is always low.
// The result appears on done once its request has passed the three register
// stages in order: lookup, scan, assembly.
// Reset clears the stage records and done, not the data registers; no request is in flight after it.
// The receiver cannot stall, so the pipeline never holds.
// ============================================================================
`default_nettype none

module interleaved_vlc_decoder
    import ivlcd_pkg::*;
#(
    parameter int WINDOW_BITS = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output      logic                   busy,
    input  wire logic [WINDOW_BITS-1:0] bit_window,
    input  wire logic [6:0]             valid_bits,
    input  wire logic                   prior_overrun,
    output      logic                   done,
    output      logic [31:0]            code_value,
    output      logic [6:0]             code_length,
    output      logic                   overrun
);

    localparam int SEGS = WINDOW_BITS / SEG_BITS;

    ivlcd_s1_t  s1;
    ivlcd_s2_t  s2;
    logic [7:0] entry [SEGS];
    logic [3:0] nib   [SEGS];

    assign busy = 1'b0;

    ivlcd_lookup #(
        .WINDOW_BITS (WINDOW_BITS),
        .SEGS        (SEGS)
    ) u_lookup (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .bit_window    (bit_window),
        .valid_bits    (valid_bits),
        .prior_overrun (prior_overrun),
        .s1            (s1),
        .entry         (entry)
    );

    ivlcd_scan #(
        .SEGS (SEGS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .entry (entry),
        .s2    (s2),
        .nib   (nib)
    );

    ivlcd_assemble #(
        .SEGS (SEGS)
    ) u_assemble (
        .clk         (clk),
        .rst_n       (rst_n),
        .s2          (s2),
        .nib         (nib),
        .done        (done),
        .code_value  (code_value),
        .code_length (code_length),
        .overrun     (overrun)
    );

`ifndef NO_ASSERTIONS
    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("Result strobe without a request three cycles earlier.");

    a_clean_end_is_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !overrun) |-> code_length[0])
        else $error("Codeword ended without overrun on an even length.");

    a_prior_overrun_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(prior_overrun, 3)) |->
            (overrun && (code_length == 7'd0) && (code_value == 32'd0)))
        else $error("Prior overrun did not give an empty result.");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ivlcd_lookup.sv -----
// ============================================================================
// ivlcd_lookup - table lookup stage
// Looks up every byte of the window in the codeword table and clamps the
// count of valid bits.
// ============================================================================
`default_nettype none

module ivlcd_lookup
    import ivlcd_pkg::*;
#(
    parameter int WINDOW_BITS = 64,
    parameter int SEGS        = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [WINDOW_BITS-1:0] bit_window,
    input  wire logic [6:0]             valid_bits,
    input  wire logic                   prior_overrun,
    output      ivlcd_s1_t              s1,
    output      logic [7:0]             entry [SEGS]
);

    ivlcd_s1_t  s1_reg;
    ivlcd_s1_t  s1_next;
    logic [7:0] entry_reg  [SEGS];
    logic [7:0] entry_next [SEGS];

    always_comb
    begin
        s1_next.valid     = start;
        s1_next.prior_ovf = prior_overrun;
        s1_next.avail     = (valid_bits > 7'(WINDOW_BITS)) ? 7'(WINDOW_BITS) : valid_bits;
        for (int i = 0; i < SEGS; i++)
        begin
            entry_next[i] = vlc_entry(bit_window[WINDOW_BITS-1-SEG_BITS*i -: SEG_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign s1    = s1_reg;
    assign entry = entry_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ivlcd_scan.sv -----
// ============================================================================
// ivlcd_scan - segment scan stage
// Walks the looked-up segments in stream order and finds where the codeword
// ends, or where the window runs out.
// ============================================================================
`default_nettype none

module ivlcd_scan
    import ivlcd_pkg::*;
#(
    parameter int SEGS = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ivlcd_s1_t  s1,
    input  wire logic [7:0] entry [SEGS],
    output      ivlcd_s2_t  s2,
    output      logic [3:0] nib [SEGS]
);

    ivlcd_s2_t  s2_reg;
    ivlcd_s2_t  s2_next;
    logic [3:0] nib_reg  [SEGS];
    logic [3:0] nib_next [SEGS];
    logic       stop;

    always_comb
    begin
        stop               = s1.prior_ovf;
        s2_next.valid      = s1.valid;
        s2_next.ovf        = s1.prior_ovf;
        s2_next.total      = 7'd0;
        s2_next.full_count = 4'd0;
        s2_next.take_odd   = 1'b0;
        s2_next.odd_len    = 4'd0;
        s2_next.odd_bits   = 4'd0;
        for (int i = 0; i < SEGS; i++)
        begin
            nib_next[i] = entry[i][3:0];
            if (!stop)
            begin
                if (s1.avail < 7'(SEG_BITS * (i + 1)))
                begin
                    s2_next.ovf = 1'b1;
                    stop        = 1'b1;
                end
                else if (entry[i][7:4] == LEN_CONTINUE)
                begin
                    s2_next.full_count = s2_next.full_count + 4'd1;
                    s2_next.total      = s2_next.total + 7'(SEG_BITS);
                end
                else
                begin
                    stop = 1'b1;
                    if (entry[i][7:4] != LEN_NONE)
                    begin
                        s2_next.take_odd = 1'b1;
                        s2_next.odd_len  = entry[i][7:4];
                        s2_next.odd_bits = entry[i][3:0];
                        s2_next.total    = s2_next.total + {3'b000, entry[i][7:4]};
                    end
                end
            end
        end
        // Every segment was a continuation, so the next peek lies past the window.
        if (!stop)
        begin
            s2_next.ovf = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nib_reg <= nib_next;
    end

    assign s2  = s2_reg;
    assign nib = nib_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ivlcd_assemble.sv -----
// ============================================================================
// ivlcd_assemble - value assembly stage
// Packs the value bits of the taken segments into the 32-bit result and
// registers the result with its strobe.
// ============================================================================
`default_nettype none

module ivlcd_assemble
    import ivlcd_pkg::*;
#(
    parameter int SEGS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ivlcd_s2_t   s2,
    input  wire logic [3:0]  nib [SEGS],
    output      logic        done,
    output      logic [31:0] code_value,
    output      logic [6:0]  code_length,
    output      logic        overrun
);

    logic        done_reg;
    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic [6:0]  length_reg;
    logic        overrun_reg;
    logic [31:0] v;

    always_comb
    begin
        v = 32'd0;
        for (int i = 0; i < SEGS; i++)
        begin
            if (4'(i) < s2.full_count)
            begin
                v = {v[23:0], 4'h0, nib[i]};
            end
        end
        value_next = v;
        if (s2.take_odd)
        begin
            case (s2.odd_len)
                4'd1:    value_next = {v[30:0], 1'b0} | {28'd0, s2.odd_bits};
                4'd3:    value_next = {v[28:0], 3'b0} | {28'd0, s2.odd_bits};
                4'd5:    value_next = {v[26:0], 5'b0} | {28'd0, s2.odd_bits};
                4'd7:    value_next = {v[24:0], 7'b0} | {28'd0, s2.odd_bits};
                default: value_next = v;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        length_reg  <= s2.total;
        overrun_reg <= s2.ovf;
    end

    assign done        = done_reg;
    assign code_value  = value_reg;
    assign code_length = length_reg;
    assign overrun     = overrun_reg;

endmodule

`default_nettype wire

// ----- verif/interleaved_vlc_decoder_test.sv -----
// ============================================================================
// interleaved_vlc_decoder_test - self-checking bench for the VLC decoder
// Drives codeword windows through the start / busy request port in bursts
// with random gaps. Each accepted request is predicted by a local model of
// the segment table unless its directed row gives the result. Each done
// strobe is compared field by field with the oldest prediction. A short
// table of directed requests comes first, then about nine hundred random ones.
// ============================================================================
`timescale 1ns / 1ps

module interleaved_vlc_decoder_test;

    localparam int WINDOW_BITS    = 64;
    localparam int RANDOM_ITEMS   = 900;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_LIMIT    = 1000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [31:0] value;
        logic [6:0]  length;
        logic        ovf;
    } codeword_t;

    typedef struct packed {
        logic [63:0] window;
        logic [6:0]  valid;
        logic        prior;
        logic        typed;
        codeword_t   result;
    } directed_row_t;

    localparam logic [63:0] ONES  = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] ZEROS = 64'h0;
    localparam int DIRECTED_ROWS  = 23;

    localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{ONES,                   7'd64,  1'b0, 1'b1, '{32'd0, 7'd1,  1'b0}},
        '{ZEROS,                  7'd64,  1'b0, 1'b1, '{32'd0, 7'd64, 1'b1}},
        '{ONES,                   7'd64,  1'b1, 1'b1, '{32'd0, 7'd0,  1'b1}},
        '{ZEROS,                  7'd0,   1'b0, 1'b1, '{32'd0, 7'd0,  1'b1}},
        '{ONES,                   7'd7,   1'b0, 1'b1, '{32'd0, 7'd0,  1'b1}},
        '{ONES,                   7'd8,   1'b0, 1'b1, '{32'd0, 7'd1,  1'b0}},
        '{ONES,                   7'd127, 1'b0, 1'b1, '{32'd0, 7'd1,  1'b0}},
        '{64'h2000_0000_0000_0000, 7'd64, 1'b0, 1'b1, '{32'd0, 7'd3,  1'b0}},
        '{64'h6000_0000_0000_0000, 7'd64, 1'b0, 1'b1, '{32'd1, 7'd3,  1'b0}},
        '{ZEROS,                  7'd0,   1'b1, 1'b1, '{32'd0, 7'd0,  1'b1}},
        '{64'h0800_0000_0000_0000, 7'd64, 1'b0, 1'b0, '0},
        '{64'h1800_0000_0000_0000, 7'd64, 1'b0, 1'b0, '0},
        '{64'h0200_0000_0000_0000, 7'd64, 1'b0, 1'b0, '0},
        '{64'h5555_5555_5555_5555, 7'd64, 1'b0, 1'b0, '0},
        '{ZEROS,                  7'd63,  1'b0, 1'b0, '0},
        '{64'h5555_5555_5555_5555, 7'd127, 1'b0, 1'b0, '0},
        '{64'h0080_0000_0000_0000, 7'd64, 1'b0, 1'b0, '0},
        '{64'h0120_0000_0000_0000, 7'd64, 1'b0, 1'b0, '0},
        '{64'haaaa_aaaa_aaaa_aaaa, 7'd64, 1'b0, 1'b0, '0},
        '{64'h0000_8000_0000_0000, 7'd15, 1'b0, 1'b0, '0},
        '{64'h5f00_0000_0000_0000, 7'd64, 1'b0, 1'b0, '0},
        '{64'h0700_0000_0000_0000, 7'd64, 1'b0, 1'b0, '0},
        '{64'h0405_0600_0000_0000, 7'd64, 1'b0, 1'b0, '0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [WINDOW_BITS-1:0] bit_window;
    logic [6:0]             valid_bits;
    logic                   prior_overrun;
    logic                   done;
    logic [31:0]            code_value;
    logic [6:0]             code_length;
    logic                   overrun;

    codeword_t pending_codewords [$];
    int        mismatch_count;
    int        cycle_count;

    interleaved_vlc_decoder #(
        .WINDOW_BITS   (WINDOW_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .bit_window    (bit_window),
        .valid_bits    (valid_bits),
        .prior_overrun (prior_overrun),
        .done          (done),
        .code_value    (code_value),
        .code_length   (code_length),
        .overrun       (overrun)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] segment_entry(input logic [7:0] idx);
        logic [3:0] grp;
        logic [1:0] k;
        logic [7:0] e;
        grp = idx[6:3];
        k   = {grp[3], grp[1]};
        if (idx[7])
        begin
            e = 8'h10;
        end
        else
        begin
            case (grp) inside
                4'd1:                   e = 8'h50;
                4'd3:                   e = 8'h51;
                4'd9:                   e = 8'h52;
                4'd11:                  e = 8'h53;
                4'd4, 4'd5, 4'd6, 4'd7: e = 8'h30;
                4'd12, 4'd13, 4'd14, 4'd15: e = 8'h31;
                default:
                begin
                    case (idx[2:0]) inside
                        3'd0:       e = 8'h80 | {4'b0, k, 2'b00};
                        3'd1:       e = 8'h80 | {4'b0, k, 2'b01};
                        3'd4:       e = 8'h80 | {4'b0, k, 2'b10};
                        3'd5:       e = 8'h80 | {4'b0, k, 2'b11};
                        3'd2, 3'd3: e = 8'h70 | {5'b0, k, 1'b0};
                        default:    e = 8'h70 | {5'b0, k, 1'b1};
                    endcase
                end
            endcase
        end
        return e;
    endfunction

    function automatic codeword_t decode_codeword(input logic [63:0] window,
                                                  input logic [6:0]  valid,
                                                  input logic        prior);
        codeword_t  r;
        int         avail;
        int         pos;
        int         total;
        int         len;
        bit         stop;
        logic [7:0] entry;
        r.value = '0;
        r.ovf   = prior;
        avail   = (valid > WINDOW_BITS) ? WINDOW_BITS : int'(valid);
        pos     = 0;
        total   = 0;
        stop    = 1'b0;
        for (int n = 0; n < 64; n++)
        begin
            if (!stop && !r.ovf)
            begin
                if (pos + 8 > avail)
                begin
                    r.ovf = 1'b1;
                end
                else
                begin
                    entry = segment_entry(window[(63 - pos) -: 8]);
                    len   = int'(entry[7:4]);
                    if (len == 0)
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        r.value = (r.value << len) | {28'b0, entry[3:0]};
                        pos     = pos + len;
                        total   = total + len;
                        if (total % 2 == 1)
                            stop = 1'b1;
                    end
                end
            end
        end
        r.length = total[6:0];
        return r;
    endfunction

    task automatic send_request(input logic [63:0] window, input logic [6:0] valid,
                                input logic prior, input logic typed,
                                input codeword_t typed_result);
        start         <= 1'b1;
        bit_window    <= window;
        valid_bits    <= valid;
        prior_overrun <= prior;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (typed)
            pending_codewords.push_back(typed_result);
        else
            pending_codewords.push_back(decode_codeword(window, valid, prior));
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic pace_burst(inout int burst_left);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 4) != 0)
                idle_for($urandom_range(1, ($urandom_range(0, 5) == 0) ? 20 : 6));
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("interleaved_vlc_decoder test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        codeword_t wanted;
        if (rst_n && done)
        begin
            if (pending_codewords.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected result: value %h length %0d overrun %b",
                             code_value, code_length, overrun);
            end
            else
            begin
                wanted = pending_codewords.pop_front();
                if (code_value !== wanted.value || code_length !== wanted.length
                    || overrun !== wanted.ovf)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                 wanted.value, wanted.length, wanted.ovf,
                                 code_value, code_length, overrun);
                end
            end
        end
    end

    initial
    begin
        logic [63:0] window;
        logic [6:0]  valid;
        logic        prior;
        int          mode;
        int          segs;
        int          burst_left;
        int          waited;
        clk            = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        bit_window    <= '0;
        valid_bits    <= '0;
        prior_overrun <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        burst_left = $urandom_range(1, 8);
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_request(DIRECTED[i].window, DIRECTED[i].valid, DIRECTED[i].prior,
                         DIRECTED[i].typed, DIRECTED[i].result);
            pace_burst(burst_left);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            mode   = $urandom_range(0, 99);
            window = {$urandom, $urandom};
            valid  = 7'd64;
            prior  = 1'b0;
            if (mode < 60)
            begin
                segs = $urandom_range(0, 8);
                for (int s = 0; s < segs; s++)
                    window[(63 - 8 * s) -: 8] = 8'($urandom) & 8'h55;
                if ($urandom_range(0, 9) < 3)
                    valid = 7'($urandom_range(0, 127));
            end
            else if (mode < 85)
            begin
                valid = 7'($urandom_range(0, 127));
                prior = ($urandom_range(0, 15) == 0);
            end
            else
            begin
                valid = 7'($urandom_range(0, 16));
                prior = ($urandom_range(0, 2) == 0);
            end
            send_request(window, valid, prior, 1'b0, '0);
            pace_burst(burst_left);
        end
        start <= 1'b0;

        waited = 0;
        while (pending_codewords.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_codewords.size() == 0)
            $display("interleaved_vlc_decoder test passed");
        else
            $display("interleaved_vlc_decoder test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ivlcd_pkg.sv
rtl/core/ivlcd_lookup.sv
rtl/core/ivlcd_scan.sv
rtl/core/ivlcd_assemble.sv
rtl/core/interleaved_vlc_decoder.sv
verif/interleaved_vlc_decoder_test.sv
